/* rtl/core/partial_sum_accumulation_bank_top_macros.svh */
// Assertion macros for the partial-sum accumulation bank.
`ifndef PARTIAL_SUM_ACCUMULATION_BANK_TOP_MACROS_SVH
`define PARTIAL_SUM_ACCUMULATION_BANK_TOP_MACROS_SVH
`ifndef SYNTH
`define PSAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PSAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSAB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSAB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/psab_pkg.sv */
// Package: shared types and constants of the partial-sum accumulation bank.
package psab_pkg;
    localparam int Depth = 256;
    localparam int Lanes = 8;

    localparam logic [2:0] FN_DESC = 3'd0;
    localparam logic [2:0] FN_WRITE = 3'd1;
    localparam logic [2:0] FN_READ = 3'd2;
    localparam logic [2:0] FN_COMPLETE = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;

    localparam logic [2:0] PH_EMPTY = 3'd0;
    localparam logic [2:0] PH_FIRST = 3'd1;
    localparam logic [2:0] PH_ACCUM = 3'd2;
    localparam logic [2:0] PH_READY = 3'd3;
    localparam logic [2:0] PH_EMIT = 3'd4;

    localparam logic [3:0] ST_OK = 4'd0;
    localparam logic [3:0] ST_BAD_DESC = 4'd1;
    localparam logic [3:0] ST_NOT_ZERO = 4'd2;
    localparam logic [3:0] ST_CTX = 4'd3;
    localparam logic [3:0] ST_BUSY = 4'd4;
    localparam logic [3:0] ST_WORD = 4'd5;
    localparam logic [3:0] ST_LAST = 4'd6;
    localparam logic [3:0] ST_OVF = 4'd7;
    localparam logic [3:0] ST_READ = 4'd8;
    localparam logic [3:0] ST_CMPL = 4'd9;

    // Back-end operation kinds chosen by the front end.
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic        first;    // store lanes instead of adding
        logic [2:0]  ph_ok;    // phase if write succeeds
        logic [2:0]  ph_cur;   // phase if no change
        logic [15:0] done_ok;  // chunk count if write succeeds
        logic [15:0] done_cur;
        logic [3:0]  status;
        logic        rd_last;
        logic [7:0]  mask;
        logic [15:0] tag;
        logic [7:0]  index;
        logic [255:0] data;
    } job_t;

    typedef struct packed {
        logic        valid;
        logic        ok;     // write committed
    } wb_t;
endpackage

/* rtl/core/partial_sum_accumulation_bank_top.sv */
// Partial-sum accumulation bank: front end, job queue and back end.
// A result passes through the job queue, the stage-1 register (store read) and the output register.
// Throughput: one request per cycle while the job queue has room, except after an accepted write,
// which blocks new requests until its overflow check retires in the back end.
// Reset (rst_n, asynchronous, active low) empties the bank and the job queue;
// the lane store is not cleared, as it is always written before it is read.
module partial_sum_accumulation_bank_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func, chunk_words, lane_mask, txn_tag, chunk_seq, chunk_flags,
    // word_index, last_word, lanes_0_1, lanes_2_3, lanes_4_5, lanes_6_7, pad
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, bank_state, out_index, out_last, out_lane_mask, out_context_tag,
    // out_lanes_0_1 .. out_lanes_6_7, chunks_done
    output logic [311:0] m_tdata
);
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    psab_pkg::job_t fq_job, qb_job;
    psab_pkg::wb_t  wb;

    // Front end classifies each request and tracks the bank state.
    psab_front u_front (
        .clk, .rst_n,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .func(s_tdata[2:0]), .chunk_words(s_tdata[11:3]),
        .lane_mask(s_tdata[19:12]), .txn_tag(s_tdata[35:20]),
        .chunk_seq(s_tdata[51:36]), .chunk_flags(s_tdata[53:52]),
        .word_index(s_tdata[61:54]), .last_word(s_tdata[62]),
        .lanes(s_tdata[318:63]),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job), .wb
    );

    psab_queue u_queue (
        .clk, .rst_n,
        .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job)
    );

    // Back end owns the lane store and the output register.
    psab_back u_back (
        .clk, .rst_n,
        .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job), .wb,
        .res_valid(m_tvalid), .res_ready(m_tready), .res_data(m_tdata)
    );
endmodule

/* rtl/core/psab_front.sv */
// Front end: decodes requests, runs the bank state machine, issues jobs.
module psab_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          func,
    input  logic [8:0]          chunk_words,
    input  logic [7:0]          lane_mask,
    input  logic [15:0]         txn_tag,
    input  logic [15:0]         chunk_seq,
    input  logic [1:0]          chunk_flags,
    input  logic [7:0]          word_index,
    input  logic                last_word,
    input  logic [255:0]        lanes,
    output logic                job_valid,
    input  logic                job_ready,
    output psab_pkg::job_t      job,
    input  psab_pkg::wb_t       wb
);
    logic [2:0]  phase_reg, phase_next;
    logic [8:0]  wc_reg, wc_next;
    logic [7:0]  mask_reg, mask_next;
    logic [15:0] tag_reg, tag_next;
    logic [8:0]  acc_reg, acc_next;
    logic [15:0] exp_reg, exp_next;
    logic [15:0] done_reg, done_next;
    logic        first_reg, first_next;
    logic        final_reg, final_next;
    logic        busy_reg, busy_next;   // write in the back end, state pending
    logic        wlast_reg, wlast_next;
    logic        fire;
    logic [15:0] done_inc, exp_inc;

    // A write decides the next state only after its overflow check.
    assign in_ready = job_ready && !busy_reg;
    assign fire = in_valid && in_ready;
    assign done_inc = (done_reg == 16'hFFFF) ? done_reg : done_reg + 16'd1;
    assign exp_inc = (exp_reg == 16'hFFFF) ? exp_reg : exp_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg; wc_next = wc_reg; mask_next = mask_reg;
        tag_next = tag_reg; acc_next = acc_reg; exp_next = exp_reg;
        done_next = done_reg; first_next = first_reg; final_next = final_reg;
        busy_next = busy_reg; wlast_next = wlast_reg;
        job_valid = 1'b0;
        job = '0;
        job.data = lanes;
        job.index = word_index;
        job.mask = mask_reg;
        job.tag = tag_reg;
        job.first = first_reg;
        job.rd_last = ({1'b0, word_index} + 9'd1 == wc_reg);
        job.done_ok = last_word ? done_inc : done_reg;
        job.ph_ok = last_word ? (final_reg ? psab_pkg::PH_EMIT : psab_pkg::PH_READY)
                              : phase_reg;
        if (wb.valid)
        begin
            busy_next = 1'b0;
            if (wb.ok)
            begin
                acc_next = acc_reg + 9'd1;
                if (wlast_reg)
                begin
                    done_next = done_inc;
                    if (!first_reg)
                        exp_next = exp_inc;
                    phase_next = final_reg ? psab_pkg::PH_EMIT : psab_pkg::PH_READY;
                end
            end
        end
        if (fire)
        begin
            job_valid = 1'b1;
            job.op = psab_pkg::OP_NONE;
            job.status = psab_pkg::ST_OK;
            unique case (func)
                psab_pkg::FN_DESC:
                begin
                    if (chunk_words == 9'd0 || chunk_words > 9'(psab_pkg::Depth)
                        || lane_mask == 8'd0)
                        job.status = psab_pkg::ST_BAD_DESC;
                    else if (phase_reg == psab_pkg::PH_EMPTY)
                    begin
                        if (!chunk_flags[0] || chunk_seq != 16'd0)
                            job.status = psab_pkg::ST_NOT_ZERO;
                        else
                        begin
                            wc_next = chunk_words; mask_next = lane_mask;
                            tag_next = txn_tag; exp_next = 16'd1;
                            done_next = 16'd0; phase_next = psab_pkg::PH_FIRST;
                            acc_next = '0; first_next = 1'b1;
                            final_next = chunk_flags[1];
                        end
                    end
                    else if (phase_reg == psab_pkg::PH_READY)
                    begin
                        if (chunk_flags[0] || chunk_words != wc_reg ||
                            lane_mask != mask_reg || txn_tag != tag_reg ||
                            chunk_seq != exp_reg)
                            job.status = psab_pkg::ST_CTX;
                        else
                        begin
                            phase_next = psab_pkg::PH_ACCUM; acc_next = '0;
                            first_next = 1'b0; final_next = chunk_flags[1];
                        end
                    end
                    else
                        job.status = psab_pkg::ST_BUSY;
                end
                psab_pkg::FN_WRITE:
                begin
                    if ((phase_reg != psab_pkg::PH_FIRST &&
                         phase_reg != psab_pkg::PH_ACCUM) ||
                        {1'b0, word_index} != acc_reg ||
                        {1'b0, word_index} >= wc_reg || lane_mask != mask_reg)
                        job.status = psab_pkg::ST_WORD;
                    else if (last_word != job.rd_last)
                        job.status = psab_pkg::ST_LAST;
                    else
                    begin
                        job.op = psab_pkg::OP_WRITE;
                        busy_next = 1'b1;
                        wlast_next = last_word;
                    end
                end
                psab_pkg::FN_READ:
                begin
                    if (phase_reg != psab_pkg::PH_EMIT || {1'b0, word_index} >= wc_reg)
                        job.status = psab_pkg::ST_READ;
                    else
                        job.op = psab_pkg::OP_READ;
                end
                psab_pkg::FN_COMPLETE, psab_pkg::FN_CLEAR:
                begin
                    if (func == psab_pkg::FN_COMPLETE && phase_reg != psab_pkg::PH_EMIT)
                        job.status = psab_pkg::ST_CMPL;
                    else
                    begin
                        phase_next = psab_pkg::PH_EMPTY; wc_next = '0; mask_next = '0;
                        tag_next = '0; acc_next = '0; exp_next = '0; done_next = '0;
                        first_next = 1'b0; final_next = 1'b0;
                    end
                end
                default: ;
            endcase
            job.ph_cur = phase_next;
            job.done_cur = done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= psab_pkg::PH_EMPTY; wc_reg <= '0; mask_reg <= '0;
            tag_reg <= '0; acc_reg <= '0; exp_reg <= '0; done_reg <= '0;
            first_reg <= 1'b0; final_reg <= 1'b0; busy_reg <= 1'b0;
            wlast_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; wc_reg <= wc_next; mask_reg <= mask_next;
            tag_reg <= tag_next; acc_reg <= acc_next; exp_reg <= exp_next;
            done_reg <= done_next; first_reg <= first_next;
            final_reg <= final_next; busy_reg <= busy_next;
            wlast_reg <= wlast_next;
        end
    end
endmodule

/* rtl/core/psab_queue.sv */
// Two-entry job queue between front and back end.
module psab_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  psab_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output psab_pkg::job_t out_job
);
    psab_pkg::job_t mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job = mem[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

/* rtl/core/psab_back.sv */
// Back end: lane store, read-modify-write accumulation, result register.
`include "partial_sum_accumulation_bank_top_macros.svh"
module psab_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  psab_pkg::job_t job,
    output psab_pkg::wb_t  wb,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [311:0]   res_data
);
    logic [255:0] store [psab_pkg::Depth];
    // stage 1: job captured together with its store word
    logic           s1_valid_reg;
    psab_pkg::job_t s1_job_reg;
    logic [255:0]   rd_reg;
    logic           out_valid_reg;
    logic [311:0]   out_reg;
    logic           take;
    logic           s1_done;
    logic [255:0]   nxt;
    logic           ovf;
    logic [32:0]    sum;
    logic [3:0]     st;
    logic [2:0]     ph;
    logic [15:0]    dn;
    logic [311:0]   res;

    assign s1_done = s1_valid_reg && (!out_valid_reg || res_ready);
    assign job_ready = !s1_valid_reg || s1_done;
    assign take = job_valid && job_ready;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_job_reg <= job;
            rd_reg <= store[job.index];
        end
        if (s1_done && s1_job_reg.op == psab_pkg::OP_WRITE && !ovf)
            store[s1_job_reg.index] <= nxt;
    end

    always_comb
    begin
        ovf = 1'b0;
        sum = '0;
        for (int k = 0; k < psab_pkg::Lanes; k++)
        begin
            sum = {s1_job_reg.data[32*k+31], s1_job_reg.data[32*k +: 32]} +
                  {rd_reg[32*k+31], rd_reg[32*k +: 32]};
            if (!s1_job_reg.mask[k])
                nxt[32*k +: 32] = '0;
            else if (s1_job_reg.first)
                nxt[32*k +: 32] = s1_job_reg.data[32*k +: 32];
            else
            begin
                nxt[32*k +: 32] = sum[31:0];
                if (sum[32] != sum[31])
                    ovf = 1'b1;
            end
        end
        st = s1_job_reg.status; ph = s1_job_reg.ph_cur; dn = s1_job_reg.done_cur;
        res = '0;
        if (s1_job_reg.op == psab_pkg::OP_WRITE)
        begin
            if (ovf)
                st = psab_pkg::ST_OVF;
            else
            begin
                ph = s1_job_reg.ph_ok; dn = s1_job_reg.done_ok;
            end
        end
        if (s1_job_reg.op == psab_pkg::OP_READ)
        begin
            res[14:7] = s1_job_reg.index;
            res[15] = s1_job_reg.rd_last;
            res[23:16] = s1_job_reg.mask;
            res[39:24] = s1_job_reg.tag;
            res[295:40] = rd_reg;
        end
        res[3:0] = st;
        res[6:4] = ph;
        res[311:296] = dn;
    end

    assign wb.valid = s1_done && s1_job_reg.op == psab_pkg::OP_WRITE;
    assign wb.ok = !ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0; out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take) s1_valid_reg <= 1'b1;
            else if (s1_done) s1_valid_reg <= 1'b0;
            if (s1_done) out_valid_reg <= 1'b1;
            else if (res_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done)
            out_reg <= res;
    end

    assign res_valid = out_valid_reg;
    assign res_data = out_reg;

    `PSAB_ASSERT_NXT(a_hold, clk, rst_n, out_valid_reg && !res_ready, out_valid_reg)
    `PSAB_ASSERT_IMP(a_wb_only_s1, clk, rst_n, wb.valid, s1_valid_reg)
    `PSAB_ASSERT_NXT(a_done_out, clk, rst_n, s1_done, out_valid_reg)
endmodule
